[hdl/dbu_pkg.sv]
`timescale 1ns / 1ps

package dbu_pkg;

  // Command codes carried in the cmd field of an input beat.
  localparam logic [2:0] CMD_CHECK    = 3'd0;
  localparam logic [2:0] CMD_TOG_ADDR = 3'd1;
  localparam logic [2:0] CMD_TOG_CODE = 3'd2;
  localparam logic [2:0] CMD_PAUSE    = 3'd3;
  localparam logic [2:0] CMD_STEP     = 3'd4;
  localparam logic [2:0] CMD_STOP     = 3'd5;
  localparam logic [2:0] CMD_RESTART  = 3'd6;

  // Run state codes.
  localparam logic [2:0] MODE_OFF       = 3'd0;
  localparam logic [2:0] MODE_PAUSED    = 3'd1;
  localparam logic [2:0] MODE_RUN       = 3'd2;
  localparam logic [2:0] MODE_STEP      = 3'd3;
  localparam logic [2:0] MODE_STEP_NEXT = 3'd4;

  // Halt causes.
  localparam logic [1:0] CAUSE_NONE = 2'd0;
  localparam logic [1:0] CAUSE_ADDR = 2'd1;
  localparam logic [1:0] CAUSE_CODE = 2'd2;
  localparam logic [1:0] CAUSE_STEP = 2'd3;

  // Toggle outcomes.
  localparam logic [1:0] TSTAT_NONE    = 2'd0;
  localparam logic [1:0] TSTAT_CLEARED = 2'd1;
  localparam logic [1:0] TSTAT_FILLED  = 2'd2;
  localparam logic [1:0] TSTAT_FULL    = 2'd3;

  // One result beat.
  typedef struct packed {
    logic       halt;
    logic [1:0] hit_cause;
    logic [1:0] toggle_status;
    logic [2:0] run_state;
    logic       audio_mute;
  } dbu_result_t;

endpackage

[hdl/dbu_if.sv]
`timescale 1ns / 1ps

// Input channel: one command beat.
interface dbu_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [31:0] pc;
  logic [31:0] instr_word;
  logic [31:0] bp_value;

  modport source (output valid, output cmd, output pc, output instr_word,
                  output bp_value, input ready);
  modport sink (input valid, input cmd, input pc, input instr_word,
                input bp_value, output ready);
endinterface

// Result channel: one result beat per command beat.
interface dbu_out_if;
  logic       valid;
  logic       ready;
  logic       halt;
  logic [1:0] hit_cause;
  logic [1:0] toggle_status;
  logic [2:0] run_state;
  logic       audio_mute;

  modport source (output valid, output halt, output hit_cause,
                  output toggle_status, output run_state, output audio_mute,
                  input ready);
  modport sink (input valid, input halt, input hit_cause, input toggle_status,
                input run_state, input audio_mute, output ready);
endinterface

[hdl/dbu_slot_table.sv]
`timescale 1ns / 1ps

module dbu_slot_table
  import dbu_pkg::*;
#(
  parameter int SLOTS = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [31:0]      key,
  input  logic             toggle_en,
  output logic [SLOTS-1:0] hit,
  output logic [1:0]       status
);

  logic [31:0]      slot_r [SLOTS];
  logic [SLOTS-1:0] eq;
  logic [SLOTS-1:0] free;
  logic [SLOTS-1:0] clr_oh;
  logic [SLOTS-1:0] fill_oh;

  // Compare the key against every slot at once.
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      eq[i]   = (slot_r[i] == key);
      free[i] = (slot_r[i] == 32'd0);
    end
  end

  // Lowest matching slot and lowest free slot, as one-hot vectors.
  assign clr_oh  = eq & (~eq + {{(SLOTS-1){1'b0}}, 1'b1});
  assign fill_oh = free & (~free + {{(SLOTS-1){1'b0}}, 1'b1});

  // A free slot never counts as a breakpoint hit.
  assign hit = eq & ~free;

  // Toggle outcome: clear a match first, otherwise fill a free slot.
  always_comb begin
    if (|eq) begin
      status = TSTAT_CLEARED;
    end else if (|free) begin
      status = TSTAT_FILLED;
    end else begin
      status = TSTAT_FULL;
    end
  end

  // Slot storage, all free after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_r[i] <= 32'd0;
      end
    end else if (toggle_en) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (|eq) begin
          if (clr_oh[i]) begin
            slot_r[i] <= 32'd0;
          end
        end else if (fill_oh[i]) begin
          slot_r[i] <= key;
        end
      end
    end
  end

endmodule

[hdl/dbu_mode_ctrl.sv]
`timescale 1ns / 1ps

module dbu_mode_ctrl
  import dbu_pkg::*;
#(
  parameter int SLOTS = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic [2:0]       cmd,
  input  logic [SLOTS-1:0] addr_hit,
  input  logic [SLOTS-1:0] code_hit,
  input  logic [1:0]       tstat,
  output dbu_result_t      result
);

  logic [2:0]       mode_r;
  logic [2:0]       mode_nxt;
  logic             mute_r;
  logic             mute_nxt;
  logic [SLOTS-1:0] any_hit;
  logic [SLOTS-1:0] first_hit;
  logic             halt;
  logic [1:0]       cause;

  // The lowest slot index with either match wins; address beats code there.
  assign any_hit   = addr_hit | code_hit;
  assign first_hit = any_hit & (~any_hit + {{(SLOTS-1){1'b0}}, 1'b1});

  // Next run state and the halt decision for the beat in flight.
  always_comb begin
    mode_nxt = mode_r;
    mute_nxt = mute_r;
    halt     = 1'b0;
    cause    = CAUSE_NONE;
    case (cmd)
      CMD_CHECK: begin
        if (mode_r == MODE_OFF || mode_r == MODE_PAUSED) begin
          halt = 1'b1;
        end else if (mode_r == MODE_STEP) begin
          mode_nxt = MODE_STEP_NEXT;
        end else if (mode_r == MODE_STEP_NEXT) begin
          mode_nxt = MODE_PAUSED;
          halt     = 1'b1;
          cause    = CAUSE_STEP;
        end else if (|any_hit) begin
          halt     = 1'b1;
          cause    = (|(first_hit & addr_hit)) ? CAUSE_ADDR : CAUSE_CODE;
          mode_nxt = MODE_PAUSED;
          mute_nxt = 1'b1;
        end
      end
      CMD_PAUSE: begin
        if (mode_r == MODE_OFF || mode_r == MODE_PAUSED) begin
          mode_nxt = MODE_RUN;
          mute_nxt = 1'b0;
        end else if (mode_r == MODE_RUN) begin
          mode_nxt = MODE_PAUSED;
          mute_nxt = 1'b1;
        end
      end
      CMD_STEP: begin
        if (mode_r == MODE_PAUSED) begin
          mode_nxt = MODE_STEP;
          mute_nxt = 1'b1;
        end else if (mode_r == MODE_RUN) begin
          mode_nxt = MODE_PAUSED;
          mute_nxt = 1'b1;
        end
      end
      CMD_STOP: begin
        mode_nxt = MODE_OFF;
        mute_nxt = 1'b1;
      end
      CMD_RESTART: begin
        if (mode_r != MODE_OFF) begin
          mode_nxt = MODE_RUN;
          mute_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Result fields report the state after the beat.
  always_comb begin
    result.halt          = halt;
    result.hit_cause     = cause;
    result.toggle_status = (cmd == CMD_TOG_ADDR || cmd == CMD_TOG_CODE) ? tstat : TSTAT_NONE;
    result.run_state     = mode_nxt;
    result.audio_mute    = mute_nxt;
  end

  // Run state and mute flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_OFF;
      mute_r <= 1'b1;
    end else if (en) begin
      mode_r <= mode_nxt;
      mute_r <= mute_nxt;
    end
  end

endmodule

[hdl/debug_breakpoint_unit.sv]
`timescale 1ns / 1ps

// Debug breakpoint unit.
// Input channel in_if carries one command beat: check (pc and instr_word),
// toggle of an address or code breakpoint (bp_value), pause, step, stop or
// restart. Result channel out_if returns exactly one result beat for every
// command beat, in order: halt, hit_cause, toggle_status, and the run state
// and audio mute flag as they stand after the command.
// An accepted beat lands in an input register; from there it is compared
// against all SLOTS address and code slots at once, the run state is
// updated, and the result is loaded into the output register once that
// register is free or being drained. One beat is taken every cycle while
// results drain; the slot comparators and the run state update finish as
// the beat moves on, so the next beat sees the state the last left.
// A stalled receiver holds the result in the output register; the input
// register still fills, then in_if.ready drops until the result drains.
// Synchronous reset (rst_n low) frees every slot, sets the run state to off
// with audio muted, and empties both registers.
module debug_breakpoint_unit
  import dbu_pkg::*;
#(
  parameter int SLOTS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  dbu_in_if.sink    in_if,
  dbu_out_if.source out_if
);

  logic             s1_valid_r;
  logic             s1_valid_nxt;
  logic [2:0]       s1_cmd_r;
  logic [31:0]      s1_pc_r;
  logic [31:0]      s1_iw_r;
  logic [31:0]      s1_val_r;
  logic             out_valid_r;
  logic             out_valid_nxt;
  dbu_result_t      out_res_r;
  dbu_result_t      res;
  logic             advance;
  logic             in_fire;
  logic             is_check;
  logic [31:0]      addr_key;
  logic [31:0]      code_key;
  logic [SLOTS-1:0] addr_hit;
  logic [SLOTS-1:0] code_hit;
  logic [1:0]       addr_stat;
  logic [1:0]       code_stat;
  logic [1:0]       tstat;

  // Handshake: the input register moves on whenever the output register is
  // free or being drained.
  assign advance     = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || advance;
  assign in_fire     = in_if.valid && in_if.ready;

  assign s1_valid_nxt  = in_fire ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = advance ? 1'b1 : (out_if.ready ? 1'b0 : out_valid_r);

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r <= in_if.cmd;
      s1_pc_r  <= in_if.pc;
      s1_iw_r  <= in_if.instr_word;
      s1_val_r <= in_if.bp_value;
    end
  end

  // A check compares pc and instr_word; a toggle looks up bp_value.
  assign is_check = (s1_cmd_r == CMD_CHECK);
  assign addr_key = is_check ? s1_pc_r : s1_val_r;
  assign code_key = is_check ? s1_iw_r : s1_val_r;

  dbu_slot_table #(.SLOTS(SLOTS)) u_addr_tab (
    .clk       (clk),
    .rst_n     (rst_n),
    .key       (addr_key),
    .toggle_en (advance && s1_cmd_r == CMD_TOG_ADDR),
    .hit       (addr_hit),
    .status    (addr_stat)
  );

  dbu_slot_table #(.SLOTS(SLOTS)) u_code_tab (
    .clk       (clk),
    .rst_n     (rst_n),
    .key       (code_key),
    .toggle_en (advance && s1_cmd_r == CMD_TOG_CODE),
    .hit       (code_hit),
    .status    (code_stat)
  );

  assign tstat = (s1_cmd_r == CMD_TOG_CODE) ? code_stat : addr_stat;

  dbu_mode_ctrl #(.SLOTS(SLOTS)) u_mode (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (advance),
    .cmd      (s1_cmd_r),
    .addr_hit (addr_hit),
    .code_hit (code_hit),
    .tstat    (tstat),
    .result   (res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.halt          = out_res_r.halt;
  assign out_if.hit_cause     = out_res_r.hit_cause;
  assign out_if.toggle_status = out_res_r.toggle_status;
  assign out_if.run_state     = out_res_r.run_state;
  assign out_if.audio_mute    = out_res_r.audio_mute;

`ifndef SYNTH
  // Every nonzero cause stops execution.
  a_cause_halts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.hit_cause != CAUSE_NONE |-> out_res_r.halt)
    else $error("hit cause reported without halt");

  // A toggle beat never reports a halt or a cause.
  a_toggle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.toggle_status != TSTAT_NONE
      |-> !out_res_r.halt && out_res_r.hit_cause == CAUSE_NONE)
    else $error("toggle result carries halt information");

  // Paused is always muted and run is never muted.
  a_mute_paused: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.run_state == MODE_PAUSED |-> out_res_r.audio_mute)
    else $error("paused without mute");

  a_mute_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.run_state == MODE_RUN |-> !out_res_r.audio_mute)
    else $error("running while muted");

  // A beat waiting in the input register moves on once the output drains.
  a_no_stuck: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_valid_r |=> out_valid_r)
    else $error("input register did not advance into a free output register");
`endif

endmodule
